// File: hw/rtl/paddle_enc_pkg.sv
// Shared types and constants for the paddle encoder axis.
package paddle_enc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_GAMEPAD_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PRESS_MS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MOUSE_STEP     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAMEPAD_STEP   = 3'd4;

  localparam logic [15:0] SHORT_PRESS_RESET  = 16'd60;
  localparam logic [15:0] LONG_PRESS_RESET   = 16'd500;
  localparam logic [7:0]  MOUSE_STEP_RESET   = 8'd1;
  localparam logic [9:0]  GAMEPAD_STEP_RESET = 10'd40;

  localparam logic [1:0] SPEED_RESET = 2'd2;
  localparam logic [1:0] SPEED_MIN   = 2'd1;
  localparam logic [1:0] SPEED_MAX   = 2'd3;

  localparam logic signed [15:0] POS_MIN = 16'sh8000;
  localparam logic signed [15:0] POS_MAX = 16'sh7FFF;

  typedef struct packed {
    logic phase_a;
    logic phase_b;
    logic ms_tick;
    logic settings_press;
    logic settings_release;
    logic center_press;
  } in_word_t;

  typedef struct packed {
    logic signed [10:0] mouse_move;
    logic signed [15:0] stick_position;
    logic [1:0]         speed_level;
    logic               reversed;
    logic               long_press_seen;
    logic               short_press_seen;
  } out_word_t;

  typedef struct packed {
    logic        gamepad_mode;
    logic [15:0] short_press_ms;
    logic [15:0] long_press_ms;
    logic [7:0]  mouse_step;
    logic [9:0]  gamepad_step;
  } cfg_t;

  typedef struct packed {
    logic               last_phase_a;
    logic               held;
    logic               long_done;
    logic [15:0]        held_ms;
    logic [1:0]         speed;
    logic               dir_reversed;
    logic signed [15:0] position;
  } axis_state_t;

endpackage

// File: hw/rtl/paddle_enc_if.sv
// Valid/ready channel interfaces for input and result words.
interface paddle_enc_in_if;
  import paddle_enc_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface paddle_enc_out_if;
  import paddle_enc_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/paddle_encoder_axis.sv
// A word accepted into the input register passes through the step logic to the result
// register. Throughput: one word per cycle while out_ch.ready does not stall; the single
// step stage between the input and result registers commits one word and state per cycle.
// While a result waits for out_ch.ready the input register takes one more word, then stalls.
// Reset (rst_n low, synchronous) empties both registers, restores register
// defaults and the axis state (speed 2, position 0, direction normal).
module paddle_encoder_axis (
  input  logic                                   clk,
  input  logic                                   rst_n,
  paddle_enc_in_if.sink                          in_ch,
  paddle_enc_out_if.source                       out_ch,
  input  logic                                   cfg_we,
  input  logic [paddle_enc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [paddle_enc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import paddle_enc_pkg::*;

  cfg_t        cfg_r;
  axis_state_t state_r;
  axis_state_t state_nxt;
  logic        s1_valid_r;
  in_word_t    s1_item_r;
  logic        out_valid_r;
  out_word_t   out_word_r;
  out_word_t   result;
  logic        adv;
  logic        commit;
  logic        in_ready;

  paddle_enc_step u_step (
    .cfg    (cfg_r),
    .st     (state_r),
    .item   (s1_item_r),
    .st_nxt (state_nxt),
    .result (result)
  );

  // result register free or being drained this cycle
  assign adv      = ~out_valid_r | out_ch.ready;
  assign commit   = adv & s1_valid_r;
  assign in_ready = ~s1_valid_r | adv;

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gamepad_mode   <= 1'b0;
      cfg_r.short_press_ms <= SHORT_PRESS_RESET;
      cfg_r.long_press_ms  <= LONG_PRESS_RESET;
      cfg_r.mouse_step     <= MOUSE_STEP_RESET;
      cfg_r.gamepad_step   <= GAMEPAD_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAMEPAD_MODE:   cfg_r.gamepad_mode   <= cfg_wdata[0];
        REG_SHORT_PRESS_MS: cfg_r.short_press_ms <= cfg_wdata[15:0];
        REG_LONG_PRESS_MS:  cfg_r.long_press_ms  <= cfg_wdata[15:0];
        REG_MOUSE_STEP:     cfg_r.mouse_step     <= cfg_wdata[7:0];
        REG_GAMEPAD_STEP:   cfg_r.gamepad_step   <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r           <= 1'b0;
      out_valid_r          <= 1'b0;
      state_r.last_phase_a <= 1'b0;
      state_r.held         <= 1'b0;
      state_r.long_done    <= 1'b0;
      state_r.held_ms      <= 16'd0;
      state_r.speed        <= SPEED_RESET;
      state_r.dir_reversed <= 1'b0;
      state_r.position     <= 16'sd0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (commit) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_item_r <= in_ch.payload;
    end
    if (commit) begin
      out_word_r <= result;
    end
  end

`ifndef ASSERT_OFF
  a_speed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.speed != 2'd0)
    else $error("speed state reached zero");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.held |-> state_r.held_ms == 16'd0)
    else $error("hold counter nonzero while button not held");

  a_speed_only_on_long: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !result.long_press_seen) |=> $stable(state_r.speed))
    else $error("speed changed without a long hold");

  a_gamepad_no_mouse: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && cfg_r.gamepad_mode) |=> out_word_r.mouse_move == 11'sd0)
    else $error("mouse move emitted in gamepad mode");
`endif

endmodule

// File: hw/rtl/paddle_enc_step.sv
// Per-word next-state and result logic: button timing, centering, encoder count.
module paddle_enc_step (
  input  paddle_enc_pkg::cfg_t        cfg,
  input  paddle_enc_pkg::axis_state_t st,
  input  paddle_enc_pkg::in_word_t    item,
  output paddle_enc_pkg::axis_state_t st_nxt,
  output paddle_enc_pkg::out_word_t   result
);
  import paddle_enc_pkg::*;

  logic               fresh;
  logic               held_a;
  logic               long_done_c;
  logic [15:0]        ms_c;
  logic [1:0]         speed_c;
  logic               rev_c;
  logic               long_seen;
  logic               short_seen;
  logic               step_edge;
  logic               step_neg;
  logic signed [2:0]  mv_mag;
  logic signed [2:0]  mv;
  logic signed [13:0] pad_delta;
  logic signed [11:0] mouse_prod;
  logic signed [15:0] pos_base;
  logic signed [16:0] pos_sum;
  logic signed [15:0] pos_c;
  logic signed [10:0] mouse_c;

  // settings button
  always_comb begin
    fresh       = item.settings_press & ~st.held;
    held_a      = st.held | item.settings_press;
    ms_c        = fresh ? 16'd0 : st.held_ms;
    long_done_c = fresh ? 1'b0 : st.long_done;
    speed_c     = st.speed;
    rev_c       = st.dir_reversed;
    long_seen   = 1'b0;
    short_seen  = 1'b0;
    if (held_a && !long_done_c) begin
      if (item.ms_tick && !fresh && (ms_c != 16'hFFFF)) begin
        ms_c = ms_c + 16'd1;
      end
      if (ms_c > cfg.long_press_ms) begin
        speed_c     = (st.speed == SPEED_MAX) ? SPEED_MIN : st.speed + 2'd1;
        long_done_c = 1'b1;
        long_seen   = 1'b1;
      end
    end
    if (item.settings_release) begin
      if ((ms_c >= cfg.short_press_ms) && (ms_c <= cfg.long_press_ms)) begin
        rev_c      = ~st.dir_reversed;
        short_seen = 1'b1;
      end
      held_a = 1'b0;
      ms_c   = 16'd0;
    end
  end

  // encoder count, uses the speed and direction left by the button logic
  always_comb begin
    step_edge  = item.phase_a & ~st.last_phase_a;
    step_neg   = item.phase_b ^ rev_c;
    mv_mag     = $signed({1'b0, speed_c});
    mv         = step_neg ? -mv_mag : mv_mag;
    pad_delta  = mv * $signed({1'b0, cfg.gamepad_step});
    mouse_prod = mv * $signed({1'b0, cfg.mouse_step});
    pos_base   = (item.center_press && cfg.gamepad_mode) ? 16'sd0 : st.position;
    pos_sum    = {pos_base[15], pos_base} + {{3{pad_delta[13]}}, pad_delta};
    pos_c      = pos_base;
    mouse_c    = 11'sd0;
    if (step_edge) begin
      if (cfg.gamepad_mode) begin
        if (pos_sum[16] != pos_sum[15]) begin
          pos_c = pos_sum[16] ? POS_MIN : POS_MAX;
        end else begin
          pos_c = pos_sum[15:0];
        end
      end else begin
        mouse_c = mouse_prod[10:0];
      end
    end
  end

  always_comb begin
    st_nxt.last_phase_a = item.phase_a;
    st_nxt.held         = held_a;
    st_nxt.long_done    = long_done_c;
    st_nxt.held_ms      = ms_c;
    st_nxt.speed        = speed_c;
    st_nxt.dir_reversed = rev_c;
    st_nxt.position     = pos_c;

    result.mouse_move       = mouse_c;
    result.stick_position   = pos_c;
    result.speed_level      = speed_c;
    result.reversed         = rev_c;
    result.long_press_seen  = long_seen;
    result.short_press_seen = short_seen;
  end

endmodule
